@@ rtl/core/crse_pkg.sv @@
// Shared constants, types and codes for the Catmull-Rom spline evaluator.
`timescale 1ns / 1ps
`default_nettype none

package crse_pkg;

    // Table and field geometry.
    localparam int MAX_POINTS = 8;
    localparam int SLOT_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = 4;
    localparam int COORD_W    = 32;
    localparam int T_W        = 17;
    localparam int FRAC_W     = 16;
    localparam int SC_W       = T_W + SLOT_W;

    // Horner accumulator: the coefficients reach twelve times a coordinate.
    localparam int ACC_W  = COORD_W + 6;
    localparam int SUM_W  = ACC_W + 2;
    localparam int HI_W   = ACC_W - FRAC_W;
    localparam int PHI_W  = HI_W + FRAC_W + 1;
    localparam int LO_W   = 2 * FRAC_W;

    // Register stages inside one axis datapath.
    localparam int AXIS_LAT = 8;

    // Request queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [T_W-1:0]   T_ONE        = T_W'(1) << FRAC_W;
    localparam logic [CNT_W-1:0] POINTS_RESET = CNT_W'(4);
    localparam logic [CNT_W-1:0] POINTS_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POINTS_MAX   = CNT_W'(MAX_POINTS);

    // Request codes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic              is_eval;
        logic [SLOT_W-1:0] slot;
        point_t            point;
        logic [SLOT_W-1:0] idx0;
        logic [SLOT_W-1:0] idx1;
        logic [SLOT_W-1:0] idx2;
        logic [SLOT_W-1:0] idx3;
        logic [FRAC_W-1:0] frac;
        logic [SLOT_W-1:0] span;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/core/crse_front.sv @@
// Front part: configuration register, request acceptance and span classification.
`timescale 1ns / 1ps
`default_nettype none

module crse_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [crse_pkg::CNT_W-1:0]        cfg_data,
    input  wire logic                              start,
    input  wire logic                              mode,
    input  wire logic [crse_pkg::SLOT_W-1:0]       point_slot,
    input  wire logic signed [crse_pkg::COORD_W-1:0] coord_x,
    input  wire logic signed [crse_pkg::COORD_W-1:0] coord_y,
    input  wire logic signed [crse_pkg::COORD_W-1:0] coord_z,
    input  wire logic [crse_pkg::T_W-1:0]          param_t,
    input  wire logic                              queue_full,
    output logic                                   busy,
    output logic                                   push,
    output crse_pkg::item_t                        push_item
);

    logic [crse_pkg::CNT_W-1:0]  points_reg;
    logic [crse_pkg::CNT_W-1:0]  points_next;
    logic [crse_pkg::CNT_W-1:0]  n_sel;
    logic [crse_pkg::SLOT_W-1:0] last;
    logic [crse_pkg::T_W-1:0]    t_sat;
    logic [crse_pkg::SC_W-1:0]   scaled;
    logic [crse_pkg::SLOT_W-1:0] seg;
    logic [crse_pkg::SLOT_W-1:0] nxt;

    always_comb
    begin
        points_next = points_reg;
        if (cfg_valid)
        begin
            points_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= crse_pkg::POINTS_RESET;
        end
        else
        begin
            points_reg <= points_next;
        end
    end

    // Clamp the point count and the parameter, then split t*(n-1).
    always_comb
    begin
        if (points_reg < crse_pkg::POINTS_MIN)
        begin
            n_sel = crse_pkg::POINTS_MIN;
        end
        else if (points_reg > crse_pkg::POINTS_MAX)
        begin
            n_sel = crse_pkg::POINTS_MAX;
        end
        else
        begin
            n_sel = points_reg;
        end
        last   = crse_pkg::SLOT_W'(n_sel - crse_pkg::CNT_W'(1));
        t_sat  = (param_t > crse_pkg::T_ONE) ? crse_pkg::T_ONE : param_t;
        scaled = crse_pkg::SC_W'(t_sat) * crse_pkg::SC_W'(last);
        seg    = scaled[crse_pkg::FRAC_W +: crse_pkg::SLOT_W];
        nxt    = (seg < last) ? seg + crse_pkg::SLOT_W'(1) : last;
    end

    always_comb
    begin
        busy                = queue_full;
        push                = start && !queue_full;
        push_item.is_eval   = (mode == crse_pkg::MODE_EVAL);
        push_item.slot      = point_slot;
        push_item.point.x   = coord_x;
        push_item.point.y   = coord_y;
        push_item.point.z   = coord_z;
        push_item.idx0      = (seg == '0) ? '0 : seg - crse_pkg::SLOT_W'(1);
        push_item.idx1      = seg;
        push_item.idx2      = nxt;
        push_item.idx3      = (nxt < last) ? nxt + crse_pkg::SLOT_W'(1) : last;
        push_item.frac      = scaled[crse_pkg::FRAC_W-1:0];
        push_item.span      = seg;
    end

endmodule

`default_nettype wire

@@ rtl/core/crse_queue.sv @@
// Short request queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module crse_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  crse_pkg::item_t      push_item,
    input  wire logic            pop,
    output logic                 head_valid,
    output crse_pkg::item_t      head,
    output logic                 full
);

    crse_pkg::item_t               entries_reg [crse_pkg::QUEUE_DEPTH];
    logic [crse_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [crse_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [crse_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [crse_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [crse_pkg::QCNT_W-1:0]   count_reg;
    logic [crse_pkg::QCNT_W-1:0]   count_next;
    logic                          pop_go;

    localparam logic [crse_pkg::QPTR_W-1:0] PTR_LAST = crse_pkg::QPTR_W'(crse_pkg::QUEUE_DEPTH - 1);

    always_comb
    begin
        head_valid  = (count_reg != '0);
        head        = entries_reg[rd_ptr_reg];
        full        = (count_reg == crse_pkg::QCNT_W'(crse_pkg::QUEUE_DEPTH));
        pop_go      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + crse_pkg::QPTR_W'(1);
        end
        if (pop_go)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + crse_pkg::QPTR_W'(1);
        end
        case ({push, pop_go})
            2'b10:   count_next = count_reg + crse_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - crse_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/crse_axis.sv @@
// Pipelined cubic blend of four control coordinates on one axis.
`timescale 1ns / 1ps
`default_nettype none

module crse_axis
(
    input  wire logic                                clk,
    input  wire logic signed [crse_pkg::COORD_W-1:0] p0,
    input  wire logic signed [crse_pkg::COORD_W-1:0] p1,
    input  wire logic signed [crse_pkg::COORD_W-1:0] p2,
    input  wire logic signed [crse_pkg::COORD_W-1:0] p3,
    input  wire logic [crse_pkg::FRAC_W-1:0]         frac,
    output logic signed [crse_pkg::COORD_W-1:0]      result
);

    localparam int ACC_W   = crse_pkg::ACC_W;
    localparam int SUM_W   = crse_pkg::SUM_W;
    localparam int FRAC_W  = crse_pkg::FRAC_W;
    localparam int COORD_W = crse_pkg::COORD_W;

    localparam logic signed [COORD_W-1:0] RES_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] RES_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic signed [ACC_W-1:0] e0, e1, e2, e3;

    // Frac and coefficient delay lines, indexed by stage.
    logic [FRAC_W-1:0]       frac_line_reg [1:5];
    logic signed [ACC_W-1:0] c_line_reg [1:2];
    logic signed [ACC_W-1:0] b_line_reg [1:4];
    logic signed [ACC_W-1:0] a_line_reg [1:6];

    logic signed [ACC_W-1:0]           acc_reg [0:3];
    logic [crse_pkg::LO_W-1:0]         plo_reg [0:2];
    logic signed [crse_pkg::PHI_W-1:0] phi_reg [0:2];
    logic signed [ACC_W-1:0]           coef_sel [0:2];
    logic signed [SUM_W-1:0]           step_sum [0:2];

    logic signed [ACC_W:0]   plus1;
    logic [ACC_W-1:0]        half;
    logic [ACC_W-COORD_W:0]  top;
    logic signed [COORD_W-1:0] res_reg;

    assign e0 = ACC_W'(p0);
    assign e1 = ACC_W'(p1);
    assign e2 = ACC_W'(p2);
    assign e3 = ACC_W'(p3);

    // Stage 1: the four cubic coefficients.
    always_ff @(posedge clk)
    begin
        frac_line_reg[1] <= frac;
        a_line_reg[1]    <= e1 <<< 1;
        b_line_reg[1]    <= e2 - e0;
        c_line_reg[1]    <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        acc_reg[0]       <= (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
        for (int s = 2; s <= 5; s++)
        begin
            frac_line_reg[s] <= frac_line_reg[s-1];
        end
        c_line_reg[2] <= c_line_reg[1];
        for (int s = 2; s <= 4; s++)
        begin
            b_line_reg[s] <= b_line_reg[s-1];
        end
        for (int s = 2; s <= 6; s++)
        begin
            a_line_reg[s] <= a_line_reg[s-1];
        end
    end

    assign coef_sel[0] = c_line_reg[2];
    assign coef_sel[1] = b_line_reg[4];
    assign coef_sel[2] = a_line_reg[6];

    // Three Horner steps, each a split multiply stage then a rounding add stage.
    // The low half product rounds half up by adding its bit below the binary point.
    for (genvar k = 0; k < 3; k++)
    begin : g_step
        assign step_sum[k] = SUM_W'(coef_sel[k]) + SUM_W'(phi_reg[k])
                           + SUM_W'($signed({1'b0, plo_reg[k][crse_pkg::LO_W-1:FRAC_W]}))
                           + SUM_W'($signed({1'b0, plo_reg[k][FRAC_W-1]}));

        always_ff @(posedge clk)
        begin
            plo_reg[k]   <= acc_reg[k][FRAC_W-1:0] * frac_line_reg[2*k+1];
            phi_reg[k]   <= $signed(acc_reg[k][ACC_W-1:FRAC_W])
                          * $signed({1'b0, frac_line_reg[2*k+1]});
            acc_reg[k+1] <= step_sum[k][ACC_W-1:0];
        end
    end

    // Final stage: halve with rounding and saturate.
    always_comb
    begin
        plus1 = (ACC_W+1)'(acc_reg[3]) + (ACC_W+1)'(1);
        half  = plus1[ACC_W:1];
        top   = half[ACC_W-1:COORD_W-1];
    end

    always_ff @(posedge clk)
    begin
        if ((&top) || !(|top))
        begin
            res_reg <= half[COORD_W-1:0];
        end
        else if (half[ACC_W-1])
        begin
            res_reg <= RES_MIN;
        end
        else
        begin
            res_reg <= RES_MAX;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/crse_back.sv @@
// Back part: point table, neighbour fetch and the three axis pipelines.
`timescale 1ns / 1ps
`default_nettype none

module crse_back
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                head_valid,
    input  crse_pkg::item_t                          head,
    output logic                                     pop,
    output logic                                     done,
    output logic signed [crse_pkg::COORD_W-1:0]      curve_x,
    output logic signed [crse_pkg::COORD_W-1:0]      curve_y,
    output logic signed [crse_pkg::COORD_W-1:0]      curve_z,
    output logic [crse_pkg::SLOT_W-1:0]              span_index
);

    localparam int LAT = crse_pkg::AXIS_LAT;

    // Two identical copies of the table, each read at two addresses.
    crse_pkg::point_t mem_a [crse_pkg::MAX_POINTS];
    crse_pkg::point_t mem_b [crse_pkg::MAX_POINTS];

    crse_pkg::point_t              rd0_reg, rd1_reg, rd2_reg, rd3_reg;
    logic [crse_pkg::FRAC_W-1:0]   frac_rd_reg;
    logic [LAT:0]                  vld_pipe_reg;
    logic [LAT:0]                  vld_pipe_next;
    logic [crse_pkg::SLOT_W-1:0]   span_pipe_reg [0:LAT];

    // The back part never stalls: it takes the queue head every cycle.
    assign pop = head_valid;

    always_ff @(posedge clk)
    begin
        if (head_valid && !head.is_eval)
        begin
            mem_a[head.slot] <= head.point;
            mem_b[head.slot] <= head.point;
        end
        rd0_reg     <= mem_a[head.idx0];
        rd1_reg     <= mem_a[head.idx1];
        rd2_reg     <= mem_b[head.idx2];
        rd3_reg     <= mem_b[head.idx3];
        frac_rd_reg <= head.frac;
    end

    assign vld_pipe_next = {vld_pipe_reg[LAT-1:0], head_valid && head.is_eval};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else
        begin
            vld_pipe_reg <= vld_pipe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_pipe_reg[0] <= head.span;
        for (int s = 1; s <= LAT; s++)
        begin
            span_pipe_reg[s] <= span_pipe_reg[s-1];
        end
    end

    crse_axis u_axis_x
    (
        .clk    (clk),
        .p0     (rd0_reg.x),
        .p1     (rd1_reg.x),
        .p2     (rd2_reg.x),
        .p3     (rd3_reg.x),
        .frac   (frac_rd_reg),
        .result (curve_x)
    );

    crse_axis u_axis_y
    (
        .clk    (clk),
        .p0     (rd0_reg.y),
        .p1     (rd1_reg.y),
        .p2     (rd2_reg.y),
        .p3     (rd3_reg.y),
        .frac   (frac_rd_reg),
        .result (curve_y)
    );

    crse_axis u_axis_z
    (
        .clk    (clk),
        .p0     (rd0_reg.z),
        .p1     (rd1_reg.z),
        .p2     (rd2_reg.z),
        .p3     (rd3_reg.z),
        .frac   (frac_rd_reg),
        .result (curve_z)
    );

    assign done       = vld_pipe_reg[LAT];
    assign span_index = span_pipe_reg[LAT];

endmodule

`default_nettype wire

@@ rtl/core/catmull_rom_spline_eval.sv @@
// Top level of the uniform Catmull-Rom spline evaluator over a 3D point table.
//
//  Channel    Handshake                Payload
//  ---------  -----------------------  ---------------------------------------------
//  config     cfg_valid / cfg_ready    cfg_data (points in use, 4 bits)
//  request    start / busy             mode, point_slot, coord_x/y/z, param_t
//  result     done (strobe, no stall)  curve_x, curve_y, curve_z, span_index
//
// One request is taken per clock cycle while busy is low. The back part drains the
// queue at the same rate, so busy only rises if the queue fills, and the sustained
// rate is one request per cycle. An evaluate request passes through the queue
// entry register and the table read registers, then the eight stages of the
// per-axis blend pipeline (three split multiplies, three rounding adds, the
// coefficient stage and the final halving and saturation).
// A load request writes the table as it leaves the queue and gives no
// result; later evaluate requests always see it. Reset clears the queue and the
// result valid pipeline and sets the point count to four; the table itself is not
// cleared. The receiver cannot hold results off, and nothing here waits on it.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_spline_eval
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [crse_pkg::CNT_W-1:0]          cfg_data,
    // Request channel.
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                mode,
    input  wire logic [crse_pkg::SLOT_W-1:0]         point_slot,
    input  wire logic signed [crse_pkg::COORD_W-1:0] coord_x,
    input  wire logic signed [crse_pkg::COORD_W-1:0] coord_y,
    input  wire logic signed [crse_pkg::COORD_W-1:0] coord_z,
    input  wire logic [crse_pkg::T_W-1:0]            param_t,
    // Result channel.
    output logic                                     done,
    output logic signed [crse_pkg::COORD_W-1:0]      curve_x,
    output logic signed [crse_pkg::COORD_W-1:0]      curve_y,
    output logic signed [crse_pkg::COORD_W-1:0]      curve_z,
    output logic [crse_pkg::SLOT_W-1:0]              span_index
);

    logic            queue_full;
    logic            push;
    crse_pkg::item_t push_item;
    logic            pop;
    logic            head_valid;
    crse_pkg::item_t head;

    // The configuration register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Front part: holds the point count, accepts requests and works out the
    // span, the local fraction and the four clamped neighbour indices.
    crse_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .start      (start),
        .mode       (mode),
        .point_slot (point_slot),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .param_t    (param_t),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .push_item  (push_item)
    );

    // Loads and evaluations share one queue so that table writes and reads keep
    // their request order.
    crse_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (queue_full)
    );

    // Back part: point table, neighbour fetch and the blend pipelines.
    crse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .curve_x    (curve_x),
        .curve_y    (curve_y),
        .curve_z    (curve_z),
        .span_index (span_index)
    );

endmodule

`default_nettype wire
